/* src/pmaq_pkg.sv */
`default_nettype none

package pmaq_pkg;

  localparam int SAMPLE_W       = 10;
  localparam int WIN_W          = 5;
  localparam int SECT_W         = 10;
  localparam int CFG_W          = 10;
  localparam int SCALE_W        = 11;
  localparam int FULL_SCALE     = 1024;
  localparam int SECTORS_ZERO   = 1023;
  localparam int RING_DEPTH_DEF = 16;

  typedef enum logic {
    REG_WINDOW  = 1'b0,
    REG_SECTORS = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

/* src/pmaq_ram.sv */
`default_nettype none

module pmaq_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/pmaq_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module pmaq_div #(
  parameter int W = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic      [W-1:0] quot_o
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [W-1:0]     dvs_q, dvs_d;
  logic [W:0]       trial;

  assign trial = {rem_q, quo_q[W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* src/pot_moving_average_qualifier_unit.sv */
`default_nettype none

// Moving-average smoother for a 10-bit potentiometer reading. Each sample beat is
// stored in a ring RAM when the window is above one; the block then walks the ring
// one entry per cycle to sum the filled window, divides by the fill count, flags a
// change when the average moved by more than one code from the last reported value,
// and gives the sector number average / (1024 / sectors). All three divisions share
// one restoring divider that produces a quotient bit per cycle. The divider is DIV_W
// = 10 + log2(RING_DEPTH) bits wide, at least 11 (14 at the default ring depth of
// 16). A window of one skips the sum walk and the first division. The first item
// after reset or after a sectors write also recomputes 1024 / sectors before the
// sector division. in_ready_o is high only while the sequencer is idle; a finished
// result waits in its output register so the next sample can be taken meanwhile.
// Writing window_size restarts the warm-up.
module pot_moving_average_qualifier_unit #(
  parameter int RING_DEPTH = pmaq_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [pmaq_pkg::SAMPLE_W-1:0] sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [pmaq_pkg::SAMPLE_W-1:0] smoothed_o,
  output logic                               changed_o,
  output logic      [pmaq_pkg::SECT_W-1:0]   sector_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [pmaq_pkg::CFG_W-1:0]    cfg_data_i
);
  import pmaq_pkg::*;

  localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW    = AW + 1;
  localparam int SUM_W = SAMPLE_W + AW;
  localparam int DIV_W = (SUM_W > SCALE_W) ? SUM_W : SCALE_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SUM  = 7'b0000010,
    S_DAVG = 7'b0000100,
    S_CMP  = 7'b0001000,
    S_DSEC = 7'b0010000,
    S_DSCT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic                launch_q, launch_d;
  logic [CW-1:0]       win_q, win_d;
  logic [SECT_W-1:0]   sectors_q, sectors_d;
  logic                sec_dirty_q, sec_dirty_d;
  logic [SCALE_W-1:0]  secdiv_q, secdiv_d;
  logic [AW-1:0]       fill_q, fill_d;
  logic [AW-1:0]       slot_q, slot_d;
  logic [SAMPLE_W-1:0] last_q, last_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [SUM_W-1:0]    acc_q, acc_d;
  logic [SAMPLE_W-1:0] avg_q, avg_d;
  logic                chg_q, chg_d;
  logic [SECT_W-1:0]   sect_q, sect_d;
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_smoothed_q, out_smoothed_d;
  logic                out_changed_q, out_changed_d;
  logic [SECT_W-1:0]   out_sector_q, out_sector_d;

  logic                in_fire;
  logic                win_gt1;
  logic [CW-1:0]       fill_p1;
  logic [CW-1:0]       slot_p1;
  logic [SAMPLE_W-1:0] diff;
  logic [WIN_W-1:0]    cfg_win;
  logic [SAMPLE_W-1:0] rd_data;
  logic                div_done;
  logic [DIV_W-1:0]    div_quot;
  logic [DIV_W-1:0]    div_dividend;
  logic [DIV_W-1:0]    div_divisor;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign win_gt1    = (win_q > CW'(1));
  assign fill_p1    = {1'b0, fill_q} + CW'(1);
  assign slot_p1    = {1'b0, slot_q} + CW'(1);
  assign diff       = (avg_q > last_q) ? (avg_q - last_q) : (last_q - avg_q);
  assign cfg_win    = cfg_data_i[WIN_W-1:0];

  pmaq_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_fire && win_gt1),
    .waddr_i (slot_q),
    .wdata_i (sample_i),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    unique case (state_q)
      S_DAVG: begin
        div_dividend = DIV_W'(acc_q);
        div_divisor  = DIV_W'(fill_p1);
      end
      S_DSEC: begin
        div_dividend = DIV_W'(FULL_SCALE);
        div_divisor  = DIV_W'(sectors_q);
      end
      default: begin
        div_dividend = DIV_W'(avg_q);
        div_divisor  = DIV_W'(secdiv_q);
      end
    endcase
  end

  pmaq_div #(
    .W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (launch_q),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d        = state_q;
    launch_d       = 1'b0;
    win_d          = win_q;
    sectors_d      = sectors_q;
    sec_dirty_d    = sec_dirty_q;
    secdiv_d       = secdiv_q;
    fill_d         = fill_q;
    slot_d         = slot_q;
    last_d         = last_q;
    cnt_d          = cnt_q;
    acc_d          = acc_q;
    avg_d          = avg_q;
    chg_d          = chg_q;
    sect_d         = sect_q;
    out_valid_d    = out_valid_q;
    out_smoothed_d = out_smoothed_q;
    out_changed_d  = out_changed_q;
    out_sector_d   = out_sector_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW: begin
          if (cfg_win == '0) begin
            win_d = CW'(1);
          end else if (int'(cfg_win) > RING_DEPTH) begin
            win_d = CW'(RING_DEPTH);
          end else begin
            win_d = CW'(cfg_win);
          end
          fill_d = '0;
          slot_d = '0;
        end
        REG_SECTORS: begin
          sectors_d   = (cfg_data_i == '0) ? SECT_W'(SECTORS_ZERO) : SECT_W'(cfg_data_i);
          sec_dirty_d = 1'b1;
        end
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cnt_d = '0;
          acc_d = '0;
          if (win_gt1) begin
            state_d = S_SUM;
          end else begin
            avg_d   = sample_i;
            state_d = S_CMP;
          end
        end
      end
      S_SUM: begin
        // the RAM read is registered, so the data arrives in the cycle after its address
        if (cnt_q != '0) begin
          acc_d = acc_q + SUM_W'(rd_data);
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == fill_p1) begin
          state_d  = S_DAVG;
          launch_d = 1'b1;
        end
      end
      S_DAVG: begin
        if (div_done) begin
          avg_d   = div_quot[SAMPLE_W-1:0];
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        chg_d = (diff > SAMPLE_W'(1));
        if (diff > SAMPLE_W'(1)) begin
          last_d = avg_q;
        end
        if (win_gt1) begin
          if (fill_p1 < win_q) begin
            fill_d = fill_p1[AW-1:0];
          end
          slot_d = (slot_p1 >= win_q) ? '0 : slot_p1[AW-1:0];
        end
        launch_d = 1'b1;
        state_d  = sec_dirty_q ? S_DSEC : S_DSCT;
      end
      S_DSEC: begin
        if (div_done) begin
          secdiv_d    = div_quot[SCALE_W-1:0];
          sec_dirty_d = 1'b0;
          launch_d    = 1'b1;
          state_d     = S_DSCT;
        end
      end
      S_DSCT: begin
        if (div_done) begin
          sect_d  = div_quot[SECT_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_smoothed_d = avg_q;
          out_changed_d  = chg_q;
          out_sector_d   = sect_q;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      win_q       <= CW'(1);
      sectors_q   <= SECT_W'(1);
      sec_dirty_q <= 1'b1;
      fill_q      <= '0;
      slot_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      win_q       <= win_d;
      sectors_q   <= sectors_d;
      sec_dirty_q <= sec_dirty_d;
      fill_q      <= fill_d;
      slot_q      <= slot_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    secdiv_q       <= secdiv_d;
    cnt_q          <= cnt_d;
    acc_q          <= acc_d;
    avg_q          <= avg_d;
    chg_q          <= chg_d;
    sect_q         <= sect_d;
    out_smoothed_q <= out_smoothed_d;
    out_changed_q  <= out_changed_d;
    out_sector_q   <= out_sector_d;
  end

  assign out_valid_o = out_valid_q;
  assign smoothed_o  = out_smoothed_q;
  assign changed_o   = out_changed_q;
  assign sector_o    = out_sector_q;

endmodule

`default_nettype wire

/* src/pmaq_checker.sv */
`default_nettype none

module pmaq_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [pmaq_pkg::SAMPLE_W-1:0] smoothed_o,
  input wire logic                          changed_o,
  input wire logic [pmaq_pkg::SECT_W-1:0]   sector_o
);
  import pmaq_pkg::*;

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // one item at a time: the sequencer is busy after taking a beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input taken again right after a beat");

  // a result never shows up the cycle after its sample
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // divisor is at least one, so the sector never exceeds the average
  a_sector_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (SECT_W'(sector_o) <= SECT_W'(smoothed_o)))
    else $error("sector above smoothed value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(smoothed_o) && $stable(changed_o) && $stable(sector_o))
    else $error("stalled result changed");

endmodule

bind pot_moving_average_qualifier_unit pmaq_checker u_pmaq_checker (.*);

`default_nettype wire
